FILE: rtl/sbis_pkg.sv
// Package: shared types and constants of the sorted bucket index store.
`default_nettype none
package sbis_pkg;

   localparam int HASH_BITS = 32;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_MISSING  = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_FULL     = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CSR_DIVISOR = 1'b0,
      CSR_LIMIT   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] score_top;
      logic [63:0] score_mid;
      logic [31:0] score_tail;
      logic [7:0]  entry_type;
      logic [63:0] entry_addr;
      logic [15:0] entry_size;
      logic [7:0]  entry_blocks;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] found_addr;
      logic [15:0] found_size;
      logic [7:0]  found_blocks;
      logic [7:0]  bucket_number;
      logic [6:0]  slot_position;
   } rsp_type;

   // Divider handshake bundle
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/sbis_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module sbis_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbis_pkg::div_req_type div_req,
   output sbis_pkg::div_rsp_type      div_rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[31]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = (div_req.divisor == '0) ? 32'd1 : div_req.divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one bit, subtract if it fits
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/sorted_bucket_index_store_top.sv
// Each request runs the bucket division, the fill read, then a search loop of decide,
// probe and compare (up to log2(BUCKET_ENTRIES)+1 probes) ending in a decision; an insert
// shifts later entries up one by one, a store writes the entry, and the response is held
// until rsp_ready. One request at a time; the next is taken in the cycle after the response
// leaves. Longest at default sizes: an insert at the front of a 63-entry bucket.
// Reset (synchronous, active high) clears fill counts and control state, sets CSR defaults.
`default_nettype none
module sorted_bucket_index_store_top #(
   parameter int NUM_BUCKETS    = 256,
   parameter int BUCKET_ENTRIES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sbis_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sbis_pkg::rsp_type     rsp_data,
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EW    = $clog2(BUCKET_ENTRIES);
   localparam int CW    = $clog2(BUCKET_ENTRIES + 1);
   localparam int AW    = BW + EW;
   localparam int DEPTH = 2 ** AW;
   localparam int PW    = CW + 1;  // signed search bounds
   localparam int LW    = (CW > 7) ? CW : 7;
   localparam int EWID  = 256;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DIV   = 11'b00000000010,
      S_FILL  = 11'b00000000100,
      S_LOAD  = 11'b00000001000,
      S_DEC   = 11'b00000010000,
      S_PROBE = 11'b00000100000,
      S_CMP   = 11'b00001000000,
      S_SHRD  = 11'b00010000000,
      S_SHWR  = 11'b00100000000,
      S_WRITE = 11'b01000000000,
      S_RSP   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] divisor_ff;
   logic [6:0]  limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= 32'd16777216;
         limit_ff   <= 7'd64;
      end else if (csr_write) begin
         case (csr_index)
            sbis_pkg::CSR_DIVISOR: divisor_ff <= csr_data;
            sbis_pkg::CSR_LIMIT:   limit_ff   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // request capture
   sbis_pkg::req_type req_ff;
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
   end
   logic [39:0]  key_tl;
   logic [167:0] key_full;
   assign key_tl   = {req_ff.score_tail, req_ff.entry_type};
   assign key_full = {req_ff.score_top, req_ff.score_mid, key_tl};

   // bucket number divider
   sbis_pkg::div_req_type div_req;
   sbis_pkg::div_rsp_type div_rsp;
   assign div_req.start    = req_valid && req_ready;
   assign div_req.dividend = req_data.score_top[63:32];
   assign div_req.divisor  = divisor_ff;
   sbis_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic [BW-1:0] bucket_ff, bucket_in;
   logic [BW-1:0] bidx;
   assign bidx = bucket_ff;

   // bucket fill memory with valid bits
   logic [CW-1:0] fill_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] fill_vld_ff;
   logic [CW-1:0] fill_rd_ff;
   logic fill_vsel_ff;
   logic fill_we;
   logic [CW-1:0] n_ff, n_in;
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[bidx] <= n_ff + CW'(1);
      fill_rd_ff   <= fill_mem[bidx];
      fill_vsel_ff <= fill_vld_ff[bidx];
   end
   always_ff @(posedge clock) begin
      if (reset) fill_vld_ff <= '0;
      else if (fill_we) fill_vld_ff[bidx] <= 1'b1;
   end

   // entry memory: key 168 bits + payload 88 bits
   logic [EWID-1:0] ent_mem [DEPTH];
   logic [EWID-1:0] ent_rd_ff, ent_wd;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic            ent_we;
   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[wr_addr] <= ent_wd;
      ent_rd_ff <= ent_mem[rd_addr];
   end

   // search registers
   logic signed [PW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in, k_ff, k_in, n_sel;
   logic hit_ff, hit_in;
   sbis_pkg::rsp_type rsp_ff, rsp_in;
   logic [LW-1:0] lim_eff;
   logic [PW-1:0] sum;

   assign lim_eff = (LW'(limit_ff) < LW'(BUCKET_ENTRIES)) ? LW'(limit_ff)
                                                           : LW'(BUCKET_ENTRIES);
   assign sum   = PW'(lo_ff + hi_ff);
   assign n_sel = fill_vsel_ff ? fill_rd_ff : '0;

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; k_in = k_ff; n_in = n_ff;
      hit_in = hit_ff; rsp_in = rsp_ff; bucket_in = bucket_ff;
      fill_we = 1'b0; ent_we = 1'b0;
      rd_addr = {bidx, mid_ff[EW-1:0]};
      wr_addr = {bidx, k_ff[EW-1:0]};
      ent_wd  = {key_full, req_ff.entry_addr, req_ff.entry_size, req_ff.entry_blocks};
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DIV;
         S_DIV: if (div_rsp.done) begin
            rsp_in = '0;
            bucket_in = div_rsp.quotient[BW-1:0];
            rsp_in.bucket_number = (div_rsp.quotient > 32'd255) ? 8'd255
                                   : div_rsp.quotient[7:0];
            if (div_rsp.quotient >= 32'(NUM_BUCKETS)) begin
               rsp_in.status = sbis_pkg::ST_RANGE;
               state_in = S_RSP;
            end else state_in = S_FILL;
         end
         S_FILL: state_in = S_LOAD;  // fill read in flight
         S_LOAD: begin
            // search bounds from the registered fill count
            n_in   = n_sel;
            lo_in  = '0;
            hi_in  = PW'(n_sel) - PW'(1);
            hit_in = 1'b0;
            state_in = S_DEC;
         end
         S_PROBE: state_in = S_CMP;  // entry read at mid in flight
         S_CMP: begin
            if (key_full == ent_rd_ff[255:88]) begin
               hit_in = 1'b1; lo_in = PW'(mid_ff);
            end else if (key_full > ent_rd_ff[255:88]) lo_in = PW'(mid_ff) + PW'(1);
            else hi_in = PW'(mid_ff) - PW'(1);
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!hit_ff && lo_ff <= hi_ff) begin
               mid_in = sum[PW-1:1];
               state_in = S_PROBE;
            end else begin
               rsp_in.slot_position = 7'(lo_ff);
               if (!req_ff.mode) begin
                  if (hit_ff) begin
                     // the last probe read still holds the matching entry
                     rsp_in.status       = sbis_pkg::ST_FOUND;
                     rsp_in.found_addr   = ent_rd_ff[87:24];
                     rsp_in.found_size   = ent_rd_ff[23:8];
                     rsp_in.found_blocks = ent_rd_ff[7:0];
                  end else begin
                     rsp_in.status = sbis_pkg::ST_MISSING;
                  end
                  state_in = S_RSP;
               end else if (hit_ff) begin
                  rsp_in.status = sbis_pkg::ST_UPDATED;
                  k_in = CW'(lo_ff);
                  state_in = S_WRITE;
               end else if (LW'(n_ff) >= lim_eff) begin
                  rsp_in.status = sbis_pkg::ST_FULL;
                  state_in = S_RSP;
               end else begin
                  rsp_in.status = sbis_pkg::ST_INSERTED;
                  mid_in = n_ff - CW'(1);
                  if (n_ff > CW'(lo_ff)) begin
                     k_in = n_ff;
                     state_in = S_SHRD;
                  end else begin
                     k_in = CW'(lo_ff);
                     state_in = S_WRITE;
                  end
               end
            end
         end
         S_SHRD: state_in = S_SHWR;  // read of k-1 in flight
         S_SHWR: begin
            // move entry k-1 up to k
            ent_we = 1'b1; ent_wd = ent_rd_ff;
            k_in = k_ff - CW'(1);
            mid_in = k_ff - CW'(2);
            state_in = (k_ff - CW'(1) > CW'(lo_ff)) ? S_SHRD : S_WRITE;
         end
         S_WRITE: begin
            ent_we = 1'b1;
            rsp_in.found_addr   = req_ff.entry_addr;
            rsp_in.found_size   = req_ff.entry_size;
            rsp_in.found_blocks = req_ff.entry_blocks;
            if (rsp_ff.status == sbis_pkg::ST_INSERTED) fill_we = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      bucket_ff <= bucket_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; k_ff <= k_in; n_ff <= n_in;
      hit_ff <= hit_in; rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while responding");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV) else $error("stray divide done");
endmodule
`default_nettype wire
